FILE: rtl/core/audio_command_frame_serializer_defines.svh
// Assertion helpers shared by the serializer RTL.
// Both expect clk and arst_n in scope.
`ifndef AUDIO_COMMAND_FRAME_SERIALIZER_DEFINES_SVH
`define AUDIO_COMMAND_FRAME_SERIALIZER_DEFINES_SVH

// Same-cycle implication.
`define ACFS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define ACFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/acfs_pkg.sv
package acfs_pkg;

	localparam int ADDRESS_BITS     = 8;
	localparam int VALUE_BITS       = 8;
	localparam int SAMPLE_BYTES     = 2;
	localparam int DATA_BITS        = ADDRESS_BITS + VALUE_BITS;
	localparam int BIT_BYTES        = 16;

	localparam int FIELD_W  = 8;
	localparam int SAMPLE_W = 8;
	localparam int LEN_W    = 10;
	localparam int LEAD_W   = 12;
	localparam int POS_W    = $clog2(BIT_BYTES);
	// bit_count runs up to DATA_BITS + 1 (parity bit done)
	localparam int BITCNT_W = $clog2(DATA_BITS + 2);

	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_ADDR_W-1:0] REG_HIGH_LEVEL = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_LOW_LEVEL  = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_LEAD_LEVEL = 2'd2;

	localparam logic [SAMPLE_W-1:0] HIGH_LEVEL_RST = 8'd255;
	localparam logic [SAMPLE_W-1:0] LOW_LEVEL_RST  = 8'd0;
	localparam logic [SAMPLE_W-1:0] LEAD_LEVEL_RST = 8'd128;

	localparam logic CMD_START   = 1'b0;
	localparam logic CMD_ADVANCE = 1'b1;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BITS,
		PH_TAIL
	} phase_t;

endpackage

FILE: rtl/core/acfs_cmd_if.sv
interface acfs_cmd_if
	import acfs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic                command;
	logic [FIELD_W-1:0]  address;
	logic [FIELD_W-1:0]  value;
	logic [LEN_W-1:0]    lead_length;

	modport source (output valid, command, address, value, lead_length, input ready);
	modport sink   (input valid, command, address, value, lead_length, output ready);
endinterface

FILE: rtl/core/acfs_smp_if.sv
interface acfs_smp_if
	import acfs_pkg::*;
;
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                last;

	modport source (output valid, sample, last, input ready);
	modport sink   (input valid, sample, last, output ready);
endinterface

FILE: rtl/core/acfs_cfg_if.sv
interface acfs_cfg_if
	import acfs_pkg::*;
;
	logic                  valid;
	logic                  ready;
	logic [CFG_ADDR_W-1:0] addr;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, addr, data, input ready);
	modport sink   (input valid, addr, data, output ready);
endinterface

FILE: rtl/core/audio_command_frame_serializer.sv
// An advance transfer's sample passes through the s1 register and then the output register to smp.
// Throughput: one command per cycle; the frame state updates as each s1 item moves on.
// Only a held output sample with smp.ready low stalls the command side.
// Reset (arst_n low, async): idle, pipeline empty, levels 255/0/128.
`include "audio_command_frame_serializer_defines.svh"

module audio_command_frame_serializer
	import acfs_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	acfs_cmd_if.sink   cmd,
	acfs_smp_if.source smp,
	acfs_cfg_if.sink   cfg
);

	logic [SAMPLE_W-1:0] high_level_q, low_level_q, lead_level_q;

	logic                valid_s1;
	logic                command_s1;
	logic [FIELD_W-1:0]  address_s1;
	logic [FIELD_W-1:0]  value_s1;
	logic [LEN_W-1:0]    lead_length_s1;

	logic                 active_q, active_d;
	phase_t               phase_q, phase_d, cur_phase;
	logic [DATA_BITS-1:0] payload_q, payload_d;
	logic [BITCNT_W-1:0]  bit_count_q, bit_count_d;
	logic [POS_W-1:0]     pos_q, pos_d;
	logic [LEAD_W-1:0]    lead_count_q, lead_count_d, lead_inc;
	logic [LEAD_W-1:0]    lead_total_q, lead_total_d;
	logic                 parity_q, parity_d;

	logic                produce;
	logic [SAMPLE_W-1:0] res_sample;
	logic                res_last;
	logic                cur_bit;
	logic                s1_fire;

	logic                smp_valid_q;
	logic [SAMPLE_W-1:0] sample_q;
	logic                last_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_level_q <= HIGH_LEVEL_RST;
			low_level_q  <= LOW_LEVEL_RST;
			lead_level_q <= LEAD_LEVEL_RST;
		end else if (cfg.valid) begin
			unique case (cfg.addr)
				REG_HIGH_LEVEL: high_level_q <= cfg.data;
				REG_LOW_LEVEL:  low_level_q  <= cfg.data;
				REG_LEAD_LEVEL: lead_level_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// frame step for the item held in s1
	always_comb begin
		active_d     = active_q;
		phase_d      = phase_q;
		payload_d    = payload_q;
		bit_count_d  = bit_count_q;
		pos_d        = pos_q;
		lead_count_d = lead_count_q;
		lead_total_d = lead_total_q;
		parity_d     = parity_q;
		produce      = 1'b0;
		res_sample   = lead_level_q;
		res_last     = 1'b0;
		cur_phase    = phase_q;
		lead_inc     = lead_count_q + 1'b1;
		cur_bit      = (bit_count_q < BITCNT_W'(DATA_BITS)) ? payload_q[DATA_BITS-1] : parity_q;

		if (command_s1 == CMD_START) begin
			payload_d    = {address_s1[ADDRESS_BITS-1:0], value_s1[VALUE_BITS-1:0]};
			parity_d     = (^address_s1[ADDRESS_BITS-1:0]) ^ (^value_s1[VALUE_BITS-1:0]);
			lead_total_d = LEAD_W'(lead_length_s1) * LEAD_W'(SAMPLE_BYTES);
			lead_count_d = '0;
			bit_count_d  = '0;
			pos_d        = '0;
			phase_d      = PH_LEAD;
			active_d     = 1'b1;
		end else if (active_q) begin
			produce = 1'b1;
			// empty lead run: go straight to the first bit
			if (phase_q == PH_LEAD && lead_count_q >= lead_total_q) begin
				cur_phase    = PH_BITS;
				phase_d      = PH_BITS;
				lead_count_d = '0;
			end
			unique case (cur_phase)
				PH_LEAD: begin
					res_sample = lead_level_q;
					if (lead_inc >= lead_total_q) begin
						phase_d      = PH_BITS;
						lead_count_d = '0;
					end else begin
						lead_count_d = lead_inc;
					end
				end
				PH_BITS: begin
					if (pos_q[0])
						res_sample = cur_bit ? high_level_q : low_level_q;
					else
						res_sample = pos_q[POS_W-1] ? low_level_q : high_level_q;
					pos_d = pos_q + 1'b1;
					if (pos_q == POS_W'(BIT_BYTES - 1)) begin
						if (bit_count_q < BITCNT_W'(DATA_BITS))
							payload_d = {payload_q[DATA_BITS-2:0], 1'b0};
						bit_count_d = bit_count_q + 1'b1;
						if (bit_count_q == BITCNT_W'(DATA_BITS)) begin
							phase_d      = PH_TAIL;
							lead_count_d = '0;
							if (lead_total_q == '0) begin
								res_last = 1'b1;
								active_d = 1'b0;
							end
						end
					end
				end
				default: begin
					res_sample   = lead_level_q;
					lead_count_d = lead_inc;
					if (lead_inc >= lead_total_q) begin
						res_last = 1'b1;
						active_d = 1'b0;
					end
				end
			endcase
		end
	end

	assign s1_fire   = valid_s1 && (!produce || !smp_valid_q || smp.ready);
	assign cmd.ready = !valid_s1 || s1_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (cmd.ready)
			valid_s1 <= cmd.valid;
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			command_s1     <= cmd.command;
			address_s1     <= cmd.address;
			value_s1       <= cmd.value;
			lead_length_s1 <= cmd.lead_length;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= 1'b0;
			phase_q      <= PH_LEAD;
			payload_q    <= '0;
			bit_count_q  <= '0;
			pos_q        <= '0;
			lead_count_q <= '0;
			lead_total_q <= '0;
			parity_q     <= 1'b0;
		end else if (s1_fire) begin
			active_q     <= active_d;
			phase_q      <= phase_d;
			payload_q    <= payload_d;
			bit_count_q  <= bit_count_d;
			pos_q        <= pos_d;
			lead_count_q <= lead_count_d;
			lead_total_q <= lead_total_d;
			parity_q     <= parity_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			smp_valid_q <= 1'b0;
		else if (s1_fire && produce)
			smp_valid_q <= 1'b1;
		else if (smp.ready)
			smp_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_fire && produce) begin
			sample_q <= res_sample;
			last_q   <= res_last;
		end
	end

	assign smp.valid  = smp_valid_q;
	assign smp.sample = sample_q;
	assign smp.last   = last_q;

	`ACFS_ASSERT_NEXT(a_last_ends_frame, s1_fire && produce && res_last, !active_q, "frame still active after last byte")
	`ACFS_ASSERT_NOW(a_idle_no_result, valid_s1 && !active_q, !produce, "result produced while idle")
	`ACFS_ASSERT_NOW(a_bit_count_range, active_q && phase_q == PH_BITS, bit_count_q <= BITCNT_W'(DATA_BITS), "bit count past parity bit")
	`ACFS_ASSERT_NOW(a_ready_when_empty, !smp_valid_q, cmd.ready, "command side stalled with empty output")

endmodule
